FILE: hw/rtl/spe_pkg.sv
// ----------------------------------------------------------------------------
// spe_pkg
// Shared types and fixed-point constants of the sinusoidal position embedding
// pipeline.
// ----------------------------------------------------------------------------
package spe_pkg;

   // Q24 log2(10000), Q30 ln(2), Q32 1/(2*pi), Q30 pi/2, Q30 one
   localparam logic [27:0] LOG2_10000_Q24 = 28'd222930821;
   localparam logic [29:0] LN2_Q30        = 30'd744261118;
   localparam logic [29:0] INV2PI_Q32     = 30'd683565276;
   localparam logic [30:0] HALFPI_Q30     = 31'd1686629713;
   localparam logic [30:0] ONE_Q30        = 31'h4000_0000;

   localparam int TERM_W    = 32;   // series term and multiplier width
   localparam int SUM_W     = 34;   // signed series accumulator width
   localparam int QUO_W     = 28;   // quotient bits of the exponent divide
   localparam int DIV_STEPS = QUO_W;
   localparam int EXP_TERMS = 12;
   localparam int SIN_TERMS = 8;

   // configuration register indexes
   localparam logic REG_MODEL_WIDTH  = 1'b0;
   localparam logic REG_PAD_POSITION = 1'b1;

   // per-request sideband that travels with the datapath
   typedef struct packed {
      logic        zero;      // force result to zero
      logic        cosine;    // column in second half of the row
      logic        neg;       // lower half of the circle
      logic [3:0]  shift;     // integer part of the exponent
      logic [11:0] position;
   } side_type;

endpackage

FILE: hw/rtl/spe_div_step.sv
// ----------------------------------------------------------------------------
// spe_div_step
// One registered step of the restoring divider: one quotient bit per stage.
// ----------------------------------------------------------------------------
module spe_div_step (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  spe_pkg::side_type            in_side,
   input  logic [11:0]                  in_div,
   input  logic [11:0]                  in_rem,
   input  logic [spe_pkg::QUO_W-1:0]    in_work,
   output logic                         out_valid,
   output spe_pkg::side_type            out_side,
   output logic [11:0]                  out_div,
   output logic [11:0]                  out_rem,
   output logic [spe_pkg::QUO_W-1:0]    out_work
);
   import spe_pkg::*;

   logic              valid_ff;
   side_type          side_ff;
   logic [11:0]       div_ff, rem_ff, rem_in;
   logic [QUO_W-1:0]  work_ff, work_in;
   logic [12:0]       trial;
   logic              ge;

   // shift in the next dividend bit, subtract when it fits
   always_comb begin
      trial   = {in_rem, in_work[QUO_W-1]};
      ge      = trial >= {1'b0, in_div};
      rem_in  = ge ? 12'(trial - {1'b0, in_div}) : trial[11:0];
      work_in = {in_work[QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= in_side;
         div_ff  <= in_div;
         rem_ff  <= rem_in;
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_div   = div_ff;
   assign out_rem   = rem_ff;
   assign out_work  = work_ff;

endmodule

FILE: hw/rtl/spe_series_stage.sv
// ----------------------------------------------------------------------------
// spe_series_stage
// One term of a power series: term = floor(floor(term*mul/2^30)/DIVISOR),
// added to or subtracted from the running sum. Three register layers.
// ----------------------------------------------------------------------------
module spe_series_stage #(
   parameter int unsigned DIVISOR = 1,
   parameter bit          NEGATE  = 1'b0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  spe_pkg::side_type                   in_side,
   input  logic [spe_pkg::TERM_W-1:0]          in_term,
   input  logic [spe_pkg::TERM_W-1:0]          in_mul,
   input  logic signed [spe_pkg::SUM_W-1:0]    in_sum,
   output logic                                out_valid,
   output spe_pkg::side_type                   out_side,
   output logic [spe_pkg::TERM_W-1:0]          out_term,
   output logic [spe_pkg::TERM_W-1:0]          out_mul,
   output logic signed [spe_pkg::SUM_W-1:0]    out_sum
);
   import spe_pkg::*;

   localparam logic [63:0] RECIP_WIDE = 64'h0000_0000_FFFF_FFFF / 64'(DIVISOR);
   localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];
   localparam logic [33:0] DIV_ONE    = 34'(DIVISOR);
   localparam logic [33:0] DIV_TWO    = 34'(2 * DIVISOR);

   logic [2:0]               valid_ff;
   side_type                 side1_ff, side2_ff, side3_ff;
   logic [TERM_W-1:0]        mul1_ff, mul2_ff, mul3_ff;
   logic signed [SUM_W-1:0]  sum1_ff, sum2_ff, sum3_ff, sum3_in;
   logic [31:0]              p1_ff, p1_in, p2_ff, q0_ff, q0_in, term3_ff, quo_in;
   logic [63:0]              prod1, prod2;
   logic [33:0]              qd, rem;

   // layer 1: product, layer 2: reciprocal estimate, layer 3: correct and sum
   always_comb begin
      prod1   = 64'(in_term) * 64'(in_mul);
      p1_in   = prod1[61:30];
      prod2   = 64'(p1_ff) * 64'(RECIP);
      q0_in   = prod2[63:32];
      qd      = {2'b00, q0_ff} * DIV_ONE;
      rem     = {2'b00, p2_ff} - qd;
      if (rem >= DIV_TWO) begin
         quo_in = q0_ff + 32'd2;
      end else if (rem >= DIV_ONE) begin
         quo_in = q0_ff + 32'd1;
      end else begin
         quo_in = q0_ff;
      end
      if (NEGATE) begin
         sum3_in = sum2_ff - $signed({2'b00, quo_in});
      end else begin
         sum3_in = sum2_ff + $signed({2'b00, quo_in});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= in_side;
         mul1_ff  <= in_mul;
         sum1_ff  <= in_sum;
         p1_ff    <= p1_in;
         side2_ff <= side1_ff;
         mul2_ff  <= mul1_ff;
         sum2_ff  <= sum1_ff;
         p2_ff    <= p1_ff;
         q0_ff    <= q0_in;
         side3_ff <= side2_ff;
         mul3_ff  <= mul2_ff;
         sum3_ff  <= sum3_in;
         term3_ff <= quo_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_side  = side3_ff;
   assign out_term  = term3_ff;
   assign out_mul   = mul3_ff;
   assign out_sum   = sum3_ff;

endmodule

FILE: hw/rtl/sinusoidal_position_embedding.sv
// ----------------------------------------------------------------------------
// sinusoidal_position_embedding
// Streams one element of the sinusoidal position embedding table per request.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  req_     | in        | tdata: position[11:0], column[23:12]
//  rsp_     | out       | tdata: value[15:0] (signed Q1.15)
//  csr_     | in        | write: 0 model_width, 1 pad_position
//
//  One request per cycle while the skid entry is empty; the depth is set by the
//  28-step divider, the 12-term exponent series and the 8-term sine series.
//  Synchronous reset clears the valid bits; model width 512, pad position 1.
//  A two-entry output (register plus skid) lets a request enter while a
//  result waits; the whole pipeline freezes only when the skid entry is full.
// ----------------------------------------------------------------------------
module sinusoidal_position_embedding #(
   parameter int MAX_POSITIONS = 4096,
   parameter int MAX_WIDTH     = 4096,
   parameter int OUT_FRAC_BITS = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // position[11:0], column[23:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // value[15:0]
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [12:0] csr_wdata
);
   import spe_pkg::*;

   localparam int          SHIFT   = 30 - OUT_FRAC_BITS;
   localparam logic [31:0] ROUND   = (SHIFT > 0) ? 32'(1) << (SHIFT - 1) : 32'd0;
   localparam logic [31:0] MAG_MAX = (32'(1) << OUT_FRAC_BITS) - 32'd1;

   // configuration
   logic [12:0] model_width_ff;
   logic [11:0] pad_position_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         model_width_ff  <= 13'd512;
         pad_position_ff <= 12'd1;
      end else if (csr_we) begin
         case (csr_index)
            REG_MODEL_WIDTH:  model_width_ff  <= csr_wdata;
            REG_PAD_POSITION: pad_position_ff <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic skid_valid_ff, rsp_valid_ff;
   logic [15:0] skid_data_ff, rsp_data_ff;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   // stage 0: capture request
   logic        v0_ff;
   logic [11:0] pos0_ff, col0_ff;

   // stage 1: width clamp, special cases, column within half
   logic        v1_ff;
   side_type    side1_ff, side1_in;
   logic [11:0] k1_ff, k1_in, d1_ff, d1_in;
   logic [12:0] w_in;
   logic [11:0] half_in;

   always_comb begin
      if (model_width_ff < 13'd4) begin
         w_in = 13'd4;
      end else if (32'(model_width_ff) > 32'(MAX_WIDTH)) begin
         w_in = 13'(MAX_WIDTH);
      end else begin
         w_in = model_width_ff;
      end
      half_in           = w_in[12:1];
      side1_in          = '0;
      side1_in.position = pos0_ff;
      side1_in.cosine   = col0_ff >= half_in;
      side1_in.zero     = (pos0_ff == pad_position_ff) ||
                          ({1'b0, col0_ff} >= {half_in, 1'b0}) ||
                          (32'(pos0_ff) >= 32'(MAX_POSITIONS));
      // drop the column of a zeroed request so the quotient stays in range
      if (side1_in.zero) begin
         k1_in = '0;
      end else begin
         k1_in = side1_in.cosine ? col0_ff - half_in : col0_ff;
      end
      d1_in = half_in - 12'd1;
   end

   // stage 2: dividend k * log2(10000)
   logic        v2_ff;
   side_type    side2_ff;
   logic [11:0] d2_ff;
   logic [39:0] prod2_ff, prod2_in;

   assign prod2_in = 40'(k1_ff) * 40'(LOG2_10000_Q24);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos0_ff  <= req_tdata[11:0];
         col0_ff  <= req_tdata[23:12];
         side1_ff <= side1_in;
         k1_ff    <= k1_in;
         d1_ff    <= d1_in;
         side2_ff <= side1_ff;
         d2_ff    <= d1_ff;
         prod2_ff <= prod2_in;
      end
   end

   // divider chain: t = k * L / (half - 1)
   logic             dv [0:DIV_STEPS];
   side_type         ds [0:DIV_STEPS];
   logic [11:0]      dd [0:DIV_STEPS];
   logic [11:0]      dr [0:DIV_STEPS];
   logic [QUO_W-1:0] dw [0:DIV_STEPS];

   assign dv[0] = v2_ff;
   assign ds[0] = side2_ff;
   assign dd[0] = d2_ff;
   assign dr[0] = prod2_ff[39:QUO_W];
   assign dw[0] = prod2_ff[QUO_W-1:0];

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      spe_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dv[i]),
         .in_side   (ds[i]),
         .in_div    (dd[i]),
         .in_rem    (dr[i]),
         .in_work   (dw[i]),
         .out_valid (dv[i+1]),
         .out_side  (ds[i+1]),
         .out_div   (dd[i+1]),
         .out_rem   (dr[i+1]),
         .out_work  (dw[i+1])
      );
   end

   // x = frac(t) * ln2, integer part of t kept as shift
   logic        vx_ff;
   side_type    sidex_ff, sidex_in;
   logic [29:0] x_ff, x_in;
   logic [53:0] xprod;

   always_comb begin
      xprod          = 54'(dw[DIV_STEPS][23:0]) * 54'(LN2_Q30);
      x_in           = xprod[53:24];
      sidex_in       = ds[DIV_STEPS];
      sidex_in.shift = dw[DIV_STEPS][27:24];
   end

   // exponent series
   logic                    ev [0:EXP_TERMS];
   side_type                es [0:EXP_TERMS];
   logic [TERM_W-1:0]       et [0:EXP_TERMS];
   logic [TERM_W-1:0]       em [0:EXP_TERMS];
   logic signed [SUM_W-1:0] esum [0:EXP_TERMS];

   assign ev[0]   = vx_ff;
   assign es[0]   = sidex_ff;
   assign et[0]   = TERM_W'(ONE_Q30);
   assign em[0]   = TERM_W'(x_ff);
   assign esum[0] = SUM_W'(ONE_Q30);

   for (genvar i = 1; i <= EXP_TERMS; i++) begin : g_exp
      spe_series_stage #(
         .DIVISOR (i),
         .NEGATE  (1'(i % 2))
      ) u_term (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (ev[i-1]),
         .in_side   (es[i-1]),
         .in_term   (et[i-1]),
         .in_mul    (em[i-1]),
         .in_sum    (esum[i-1]),
         .out_valid (ev[i]),
         .out_side  (es[i]),
         .out_term  (et[i]),
         .out_mul   (em[i]),
         .out_sum   (esum[i])
      );
   end

   // freq = clamp(sum) >> n
   logic        vf_ff;
   side_type    sidef_ff;
   logic [30:0] freq_ff, freq_in;

   always_comb begin
      if (esum[EXP_TERMS] < 0) begin
         freq_in = '0;
      end else begin
         freq_in = esum[EXP_TERMS][30:0] >> es[EXP_TERMS].shift;
      end
   end

   // angle = position * freq
   logic        va_ff;
   side_type    sidea_ff;
   logic [42:0] angle_ff, angle_in;

   assign angle_in = 43'(sidef_ff.position) * 43'(freq_ff);

   // phase in turns: low part first, then high part
   logic        vp1_ff;
   side_type    sidep1_ff;
   logic [12:0] ah_ff;
   logic [29:0] lo_ff, lo_in;
   logic [59:0] loprod;

   always_comb begin
      loprod = 60'(angle_ff[29:0]) * 60'(INV2PI_Q32);
      lo_in  = loprod[59:30];
   end

   logic        vp2_ff;
   side_type    sidep2_ff;
   logic [31:0] phase_ff, phase_in;
   logic [42:0] hiprod;

   always_comb begin
      hiprod   = 43'(ah_ff) * 43'(INV2PI_Q32);
      phase_in = 32'(hiprod) + 32'(lo_ff);
      if (sidep1_ff.cosine) begin
         phase_in = phase_in + 32'(ONE_Q30);
      end
   end

   // fold into the first quadrant
   logic        vp3_ff;
   side_type    sidep3_ff, sidep3_in;
   logic [30:0] v_ff, v_in;

   always_comb begin
      sidep3_in     = sidep2_ff;
      sidep3_in.neg = phase_ff[31];
      if (phase_ff[30]) begin
         v_in = ONE_Q30 - {1'b0, phase_ff[29:0]};
      end else begin
         v_in = {1'b0, phase_ff[29:0]};
      end
   end

   // theta = v * pi/2, then theta squared
   logic        vt1_ff;
   side_type    sidet1_ff;
   logic [31:0] theta1_ff, theta1_in;
   logic [61:0] thprod;

   always_comb begin
      thprod    = 62'(v_ff) * 62'(HALFPI_Q30);
      theta1_in = thprod[61:30];
   end

   logic        vt2_ff;
   side_type    sidet2_ff;
   logic [31:0] theta2_ff, th2_ff, th2_in;
   logic [63:0] sqprod;

   always_comb begin
      sqprod = 64'(theta1_ff) * 64'(theta1_ff);
      th2_in = sqprod[61:30];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vx_ff  <= 1'b0;
         vf_ff  <= 1'b0;
         va_ff  <= 1'b0;
         vp1_ff <= 1'b0;
         vp2_ff <= 1'b0;
         vp3_ff <= 1'b0;
         vt1_ff <= 1'b0;
         vt2_ff <= 1'b0;
      end else if (en) begin
         vx_ff  <= dv[DIV_STEPS];
         vf_ff  <= ev[EXP_TERMS];
         va_ff  <= vf_ff;
         vp1_ff <= va_ff;
         vp2_ff <= vp1_ff;
         vp3_ff <= vp2_ff;
         vt1_ff <= vp3_ff;
         vt2_ff <= vt1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sidex_ff  <= sidex_in;
         x_ff      <= x_in;
         sidef_ff  <= es[EXP_TERMS];
         freq_ff   <= freq_in;
         sidea_ff  <= sidef_ff;
         angle_ff  <= angle_in;
         sidep1_ff <= sidea_ff;
         ah_ff     <= angle_ff[42:30];
         lo_ff     <= lo_in;
         sidep2_ff <= sidep1_ff;
         phase_ff  <= phase_in;
         sidep3_ff <= sidep3_in;
         v_ff      <= v_in;
         sidet1_ff <= sidep3_ff;
         theta1_ff <= theta1_in;
         sidet2_ff <= sidet1_ff;
         theta2_ff <= theta1_ff;
         th2_ff    <= th2_in;
      end
   end

   // sine series
   logic                    sv [0:SIN_TERMS];
   side_type                ss [0:SIN_TERMS];
   logic [TERM_W-1:0]       st [0:SIN_TERMS];
   logic [TERM_W-1:0]       sm [0:SIN_TERMS];
   logic signed [SUM_W-1:0] ssum [0:SIN_TERMS];

   assign sv[0]   = vt2_ff;
   assign ss[0]   = sidet2_ff;
   assign st[0]   = theta2_ff;
   assign sm[0]   = th2_ff;
   assign ssum[0] = $signed({2'b00, theta2_ff});

   for (genvar i = 1; i <= SIN_TERMS; i++) begin : g_sin
      spe_series_stage #(
         .DIVISOR ((2 * i) * (2 * i + 1)),
         .NEGATE  (1'(i % 2))
      ) u_term (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sv[i-1]),
         .in_side   (ss[i-1]),
         .in_term   (st[i-1]),
         .in_mul    (sm[i-1]),
         .in_sum    (ssum[i-1]),
         .out_valid (sv[i]),
         .out_side  (ss[i]),
         .out_term  (st[i]),
         .out_mul   (sm[i]),
         .out_sum   (ssum[i])
      );
   end

   // final: clamp, round, saturate, apply sign
   logic        vo_ff;
   logic [15:0] value_ff, value_in;
   logic [30:0] s_clamp;
   logic [31:0] mag, mag_pos;
   side_type    side_last;

   always_comb begin
      side_last = ss[SIN_TERMS];
      if (ssum[SIN_TERMS] < 0) begin
         s_clamp = '0;
      end else if (ssum[SIN_TERMS] > $signed(SUM_W'(ONE_Q30))) begin
         s_clamp = ONE_Q30;
      end else begin
         s_clamp = ssum[SIN_TERMS][30:0];
      end
      mag     = (32'(s_clamp) + ROUND) >> SHIFT;
      mag_pos = (mag > MAG_MAX) ? MAG_MAX : mag;
      if (side_last.zero) begin
         value_in = '0;
      end else if (side_last.neg) begin
         value_in = (mag > 32'd32768) ? 16'h8000 : 16'(32'd0 - mag);
      end else begin
         value_in = (mag_pos > 32'd32767) ? 16'h7fff : mag_pos[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= sv[SIN_TERMS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff <= value_in;
      end
   end

   // output register with skid entry behind it
   logic rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= vo_ff;
         end
      end else if (en && vo_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : value_ff;
      end else if (en && vo_ff) begin
         skid_data_ff <= value_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry holds data while output register is empty");

   a_skid_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && vo_ff && en) |=> !req_tready)
      else $error("request accepted with the skid entry full");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      dv[DIV_STEPS] |-> (dr[DIV_STEPS] < dd[DIV_STEPS]))
      else $error("divider remainder not below divisor");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (en && sv[SIN_TERMS] && ss[SIN_TERMS].zero) |=> (value_ff == 16'd0))
      else $error("padding or out-of-row element not zero");
`endif

endmodule
